/* hdl/rgbds_pkg.sv */
// ----------------------------------------------------------------------------
// rgbds_pkg
// Shared types, register codes and pixel helpers for the RGB565 bilinear
// downscaler.
// ----------------------------------------------------------------------------
package rgbds_pkg;

  // Default sizes
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_DEST_SIZE  = 64;

  // Configuration register indexes
  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_OUT_MODE   = 2'd2;

  // Configuration reset values
  localparam logic [9:0] RST_SRC_WIDTH  = 10'd240;
  localparam logic [9:0] RST_SRC_HEIGHT = 10'd320;
  localparam logic       RST_OUT_MODE   = 1'b0;

  // Q1.15 full scale
  localparam logic [15:0] Q_ONE = 16'd32768;

  // Channel value width: luma numerator peaks at 1953000
  localparam int CV_W = 21;

  // BT.601 luma weights on raw fields, scaled to a common denominator
  localparam logic [CV_W-1:0] LUMA_R = 21'd18837;  // 299*63
  localparam logic [CV_W-1:0] LUMA_G = 21'd18197;  // 587*31
  localparam logic [CV_W-1:0] LUMA_B = 21'd7182;   // 114*63

  // Lane codes
  localparam logic [1:0] LANE_RED   = 2'd0;
  localparam logic [1:0] LANE_GREEN = 2'd1;
  localparam logic [1:0] LANE_BLUE  = 2'd2;
  localparam int NUM_LANES = 3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NPROD,
    ST_RECIP,
    ST_COMMIT,
    ST_MIX1,
    ST_MIX2,
    ST_DIV,
    ST_DONE
  } state_t;

  // floor(c*255/31) = 8c + floor(7c/31)
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [7:0] s;
    logic [2:0] cnt;
    s   = 8'(c) * 8'd7;
    cnt = 3'd0;
    for (int k = 1; k <= 7; k++) begin
      if (s >= 8'(31 * k)) cnt = cnt + 3'd1;
    end
    return {c, 3'b000} + 8'(cnt);
  endfunction

  // floor(c*255/63) = 4c + floor(c/21)
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [1:0] cnt;
    cnt = 2'd0;
    if (c >= 6'd21) cnt = cnt + 2'd1;
    if (c >= 6'd42) cnt = cnt + 2'd1;
    if (c >= 6'd63) cnt = cnt + 2'd1;
    return {c, 2'b00} + 8'(cnt);
  endfunction

  // Per-lane source value: expanded color or exact luma numerator
  function automatic logic [CV_W-1:0] chan_val(input logic [15:0] p,
                                               input logic [1:0]  lane,
                                               input logic        gray);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    logic [CV_W-1:0] v;
    r = p[15:11];
    g = p[10:5];
    b = p[4:0];
    if (gray) begin
      v = CV_W'(r) * LUMA_R + CV_W'(g) * LUMA_G + CV_W'(b) * LUMA_B;
    end else begin
      unique case (lane)
        LANE_RED:   v = CV_W'(expand5(r));
        LANE_GREEN: v = CV_W'(expand6(g));
        LANE_BLUE:  v = CV_W'(expand5(b));
        default:    v = '0;
      endcase
    end
    return v;
  endfunction

endpackage

/* hdl/rgb565_bilinear_downscale_64.sv */
// ----------------------------------------------------------------------------
// rgb565_bilinear_downscale_64
// Streaming corner-aligned bilinear downscaler: RGB565 raster in, square
// DEST_SIZE image out as Q1.15 levels, color or replicated luma.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  in       | input     | in_valid / in_stall  | in_pixel, in_frame_start
//  out      | output    | out_valid / out_stall| out_x, out_y, out_*_level,
//           |           |                      | out_frame_done
//  cfg      | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
//  A pixel past the last source row is accepted with no further steps. A pixel
//  that yields no result passes through line store read, position products,
//  reciprocal and commit; one that yields a result also passes through the two
//  mixing steps and the three-step reciprocal division (estimate, back-multiply,
//  correction) that normalizes the three lanes, plus the output load.
//  Reset clears counters and config; the line store is not cleared.
//  A result waits in the output register while the next pixel is taken;
//  a new result is held back only while that register is still full.
// ----------------------------------------------------------------------------
module rgb565_bilinear_downscale_64
  import rgbds_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int DEST_SIZE  = DEF_DEST_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pixel,
  input  logic        in_frame_start,
  // result stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_x,
  output logic [5:0]  out_y,
  output logic [15:0] out_red_level,
  output logic [15:0] out_green_level,
  output logic [15:0] out_blue_level,
  output logic        out_frame_done,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  localparam int K    = DEST_SIZE - 1;
  localparam int KW   = $clog2(DEST_SIZE);
  localparam int TW   = KW + 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int NW   = $clog2(K * (MAXD - 1) + 1);
  localparam int PW   = 2 * NW + 1;
  localparam logic [NW:0] RECIP = (NW + 1)'((2 ** NW) / K);
  localparam int TPW  = CV_W + KW;
  localparam int NMW  = TPW + KW;
  localparam int DW   = NMW + 16;
  localparam int DENW = CV_W + 2 * KW;
  localparam logic [63:0] DEN_COLOR64 = 64'd255 * 64'(K) * 64'(K);
  localparam logic [63:0] DEN_GRAY64  = 64'd1953000 * 64'(K) * 64'(K);
  localparam logic [DENW-1:0] DEN_COLOR  = DENW'(DEN_COLOR64);
  localparam logic [DENW-1:0] DEN_GRAY   = DENW'(DEN_GRAY64);
  localparam logic [DENW-1:0] HALF_COLOR = DENW'(DEN_COLOR64 / 64'd2);
  localparam logic [DENW-1:0] HALF_GRAY  = DENW'(DEN_GRAY64 / 64'd2);
  localparam logic [KW-1:0] KV = KW'(K);

  // reciprocal division: dividend top bits times scaled 1/den, one fix-up
  localparam int T_COLOR = $clog2(DEN_COLOR64 + 64'd1) - 6;
  localparam int T_GRAY  = $clog2(DEN_GRAY64 + 64'd1) - 6;
  localparam int RSH     = 24;
  localparam int XTW     = 22;
  localparam int MW      = 20;
  localparam logic [MW-1:0] M_COLOR = MW'((64'd1 << (T_COLOR + RSH)) / DEN_COLOR64);
  localparam logic [MW-1:0] M_GRAY  = MW'((64'd1 << (T_GRAY + RSH)) / DEN_GRAY64);
  localparam logic [1:0] DIV_EST = 2'd0;
  localparam logic [1:0] DIV_MUL = 2'd1;
  localparam logic [1:0] DIV_FIX = 2'd2;

  // configuration registers
  logic [9:0] src_width_r, src_height_r;
  logic       out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      out_mode_r   <= RST_OUT_MODE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        CFG_OUT_MODE:   out_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (32'(src_width_r) < 32'(DEST_SIZE))      w = WW'(DEST_SIZE);
    else if (32'(src_width_r) > 32'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else                                        w = WW'(src_width_r);
    if (32'(src_height_r) < 32'(DEST_SIZE))       h = HW'(DEST_SIZE);
    else if (32'(src_height_r) > 32'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
    else                                          h = HW'(src_height_r);
  end

  // sequencer
  state_t state_r, state_nxt;
  logic   in_acc, skip, emit, load_out, mem_re, mem_we;
  logic [1:0] div_cnt_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_acc    = 1'b0;
    load_out  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_acc    = 1'b1;
          mem_re    = 1'b1;
          state_nxt = skip ? ST_IDLE : ST_NPROD;
        end
      end
      ST_NPROD: state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        mem_we    = 1'b1;
        state_nxt = emit ? ST_MIX1 : ST_IDLE;
      end
      ST_MIX1: state_nxt = ST_MIX2;
      ST_MIX2: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == DIV_FIX) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  // position state
  logic [CW-1:0] col_r;
  logic [HW-1:0] row_r;
  logic [TW-1:0] tc_r, tr_r;
  logic [15:0]   lf_r, ul_r, pix_r;

  // frame start and row wrap applied ahead of the pixel
  logic [CW-1:0] col0, col1;
  logic [HW-1:0] row0, row1;
  logic [TW-1:0] tc0, tc1, tr0;
  logic          wrap;

  always_comb begin
    col0 = in_frame_start ? '0 : col_r;
    row0 = in_frame_start ? '0 : row_r;
    tc0  = in_frame_start ? '0 : tc_r;
    tr0  = in_frame_start ? '0 : tr_r;
    wrap = 32'(col0) >= 32'(w);
    col1 = wrap ? '0 : col0;
    tc1  = wrap ? '0 : tc0;
    row1 = (wrap && (32'(row0) < 32'(h))) ? row0 + HW'(1) : row0;
    skip = 32'(row1) >= 32'(h);
  end

  // line store: read on transfer, written back at commit, never both at once
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] up_r;

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[col_r] <= pix_r;
    if (mem_re) up_r <= line_mem[col1];
  end

  // emission positions: n = t*(s-1), low = n/K by reciprocal with one fix-up
  logic [NW-1:0] nc_r, nr_r, lc_r, lr_r;
  logic [NW-1:0] rc0, rr0, lowc, lowr, ec, er;
  logic [KW-1:0] remc, remr, wc, wr;
  logic          act;

  always_comb begin
    rc0 = nc_r - NW'(lc_r * NW'(K));
    rr0 = nr_r - NW'(lr_r * NW'(K));
    if (rc0 >= NW'(K)) begin
      lowc = lc_r + NW'(1);
      remc = KW'(rc0 - NW'(K));
    end else begin
      lowc = lc_r;
      remc = KW'(rc0);
    end
    if (rr0 >= NW'(K)) begin
      lowr = lr_r + NW'(1);
      remr = KW'(rr0 - NW'(K));
    end else begin
      lowr = lr_r;
      remr = KW'(rr0);
    end
    ec   = lowc + NW'(remc != '0);
    er   = lowr + NW'(remr != '0);
    wc   = (remc != '0) ? remc : KV;
    wr   = (remr != '0) ? remr : KV;
    act  = (32'(tc_r) < 32'(DEST_SIZE)) && (32'(tr_r) < 32'(DEST_SIZE));
    emit = act && (32'(row_r) >= 32'(er)) && (32'(col_r) >= 32'(ec));
  end

  // next column after commit
  logic [CW:0] col_inc;
  assign col_inc = {1'b0, col_r} + (CW + 1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      tc_r  <= '0;
      tr_r  <= '0;
      lf_r  <= '0;
      ul_r  <= '0;
    end else if (in_acc) begin
      col_r <= col1;
      row_r <= row1;
      tc_r  <= tc1;
      tr_r  <= tr0;
      if (in_frame_start) begin
        lf_r <= '0;
        ul_r <= '0;
      end
    end else if (state_r == ST_COMMIT) begin
      ul_r <= up_r;
      lf_r <= pix_r;
      if (emit) begin
        tr_r <= (tc_r == TW'(K)) ? tr_r + TW'(1) : tr_r;
        tc_r <= (tc_r == TW'(K)) ? TW'(DEST_SIZE) : tc_r + TW'(1);
      end
      if (32'(col_inc) >= 32'(w)) begin
        col_r <= '0;
        tc_r  <= '0;
        row_r <= row_r + HW'(1);
      end else begin
        col_r <= CW'(col_inc);
      end
    end
  end

  // position products and reciprocal estimates
  logic [PW-1:0] pc, pr;
  assign pc = PW'(nc_r) * PW'(RECIP);
  assign pr = PW'(nr_r) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (in_acc) pix_r <= in_pixel;
    if (state_r == ST_NPROD) begin
      nc_r <= NW'(KW'(tc_r)) * NW'(w - WW'(1));
      nr_r <= NW'(KW'(tr_r)) * NW'(h - HW'(1));
    end
    if (state_r == ST_RECIP) begin
      lc_r <= NW'(pc >> NW);
      lr_r <= NW'(pr >> NW);
    end
  end

  // interpolation lanes and reciprocal divider
  logic [15:0]   a_ul_r, a_up_r, a_lf_r, a_cur_r;
  logic [KW-1:0] wc_r, wr_r;
  logic [5:0]    ox_r, oy_r;
  logic          last_r;
  logic [TPW-1:0] top_r [NUM_LANES];
  logic [TPW-1:0] bot_r [NUM_LANES];
  logic [DW-1:0]   x_r  [NUM_LANES];
  logic [DW-1:0]   pd_r [NUM_LANES];
  logic [15:0]     q_r  [NUM_LANES];
  logic [DENW-1:0] den, half;
  logic [MW-1:0]   recip_m;

  assign den     = out_mode_r ? DEN_GRAY  : DEN_COLOR;
  assign half    = out_mode_r ? HALF_GRAY : HALF_COLOR;
  assign recip_m = out_mode_r ? M_GRAY    : M_COLOR;

  always_ff @(posedge clk) begin
    logic [NMW-1:0]  num;
    logic [DW-1:0]   dvd;
    logic [XTW-1:0]  xt;
    logic [XTW+MW-1:0] pm;
    logic [CV_W-1:0] v0, v1, v2, v3;
    if (state_r == ST_COMMIT) begin
      a_ul_r  <= (col_r == '0) ? '0 : ul_r;
      a_lf_r  <= (col_r == '0) ? '0 : lf_r;
      a_up_r  <= up_r;
      a_cur_r <= pix_r;
      wc_r    <= wc;
      wr_r    <= wr;
      ox_r    <= 6'(tc_r);
      oy_r    <= 6'(tr_r);
      last_r  <= (tc_r == TW'(K)) && (tr_r == TW'(K));
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      if (state_r == ST_MIX1) begin
        v0 = chan_val(a_ul_r,  2'(l), out_mode_r);
        v1 = chan_val(a_up_r,  2'(l), out_mode_r);
        v2 = chan_val(a_lf_r,  2'(l), out_mode_r);
        v3 = chan_val(a_cur_r, 2'(l), out_mode_r);
        top_r[l] <= TPW'(v0) * TPW'(KV - wc_r) + TPW'(v1) * TPW'(wc_r);
        bot_r[l] <= TPW'(v2) * TPW'(KV - wc_r) + TPW'(v3) * TPW'(wc_r);
      end
      if (state_r == ST_MIX2) begin
        num = NMW'(top_r[l]) * NMW'(KV - wr_r) + NMW'(bot_r[l]) * NMW'(wr_r);
        dvd = (DW'(num) << 15) + DW'(half);
        x_r[l] <= dvd;
      end
      if (state_r == ST_DIV) begin
        unique case (div_cnt_r)
          // estimate is exact or one low
          DIV_EST: begin
            xt = out_mode_r ? XTW'(x_r[l] >> T_GRAY) : XTW'(x_r[l] >> T_COLOR);
            pm = (XTW + MW)'(xt) * (XTW + MW)'(recip_m);
            q_r[l] <= pm[RSH+15:RSH];
          end
          DIV_MUL: pd_r[l] <= DW'(q_r[l]) * DW'(den);
          DIV_FIX: begin
            if (x_r[l] - pd_r[l] >= DW'(den)) q_r[l] <= q_r[l] + 16'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                  div_cnt_r <= '0;
    else if (state_r == ST_MIX2) div_cnt_r <= '0;
    else if (state_r == ST_DIV)  div_cnt_r <= div_cnt_r + 2'd1;
  end

  // output register
  logic [5:0]  ox_o_r, oy_o_r;
  logic [15:0] red_o_r, grn_o_r, blu_o_r;
  logic        done_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n)               out_valid_r <= 1'b0;
    else if (load_out)        out_valid_r <= 1'b1;
    else if (!out_stall)      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ox_o_r   <= ox_r;
      oy_o_r   <= oy_r;
      red_o_r  <= (q_r[LANE_RED]   > Q_ONE) ? Q_ONE : q_r[LANE_RED];
      grn_o_r  <= (q_r[LANE_GREEN] > Q_ONE) ? Q_ONE : q_r[LANE_GREEN];
      blu_o_r  <= (q_r[LANE_BLUE]  > Q_ONE) ? Q_ONE : q_r[LANE_BLUE];
      done_o_r <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = ox_o_r;
  assign out_y           = oy_o_r;
  assign out_red_level   = red_o_r;
  assign out_green_level = grn_o_r;
  assign out_blue_level  = blu_o_r;
  assign out_frame_done  = done_o_r;

  // checks
  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("line store read and write in the same cycle");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_o_r |-> (ox_o_r == 6'(K)) && (oy_o_r == 6'(K)))
    else $error("frame_done away from the last destination pixel");

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (red_o_r <= Q_ONE) && (grn_o_r <= Q_ONE) && (blu_o_r <= Q_ONE))
    else $error("level above full scale");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COMMIT |-> 32'(col_r) < 32'(w))
    else $error("column past row end at commit");

  a_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> !$past(load_out))
    else $error("result overwritten while stalled");

endmodule
